>>> hw/rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared constants, codes, result record and character helpers.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int NSC_MAX_LEN = 128;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_R      = 8'h52;

    localparam logic [4:0] FIELD_MAX    = 5'd31;
    localparam logic [4:0] FIELD_STATUS = 5'd2;
    localparam logic [4:0] FIELD_FIX    = 5'd6;
    localparam logic [1:0] COMMA_MAX    = 2'd3;
    localparam int         ADDR_LEN     = 5;

    typedef enum logic [1:0] {
        TM_NONE   = 2'd0,
        TM_GGA    = 2'd1,
        TM_RMC    = 2'd2,
        TM_PREFIX = 2'd3
    } type_match_t;

    typedef enum logic [1:0] {
        SP_BODY = 2'd0,
        SP_HI   = 2'd1,
        SP_LO   = 2'd2,
        SP_DONE = 2'd3
    } sum_phase_t;

    localparam logic [1:0] TYPE_OTHER = 2'd0;
    localparam logic [1:0] TYPE_GGA   = 2'd1;
    localparam logic [1:0] TYPE_RMC   = 2'd2;

    typedef struct packed {
        logic [1:0] sentence_type;
        logic       checksum_ok;
        logic [7:0] checksum_value;
        logic       accepted;
        logic [7:0] fix_char;
        logic [7:0] status_char;
        logic       malformed;
    } nsc_verdict_t;

    function automatic logic [7:0] gga_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h47;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rmc_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h4D;
            3'd4:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Bit 4 flags a byte that is not a hex digit; its nibble is then zero.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h57)};
        end else begin
            v = 5'b10000;
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/nsc_step.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker parse step
// Holds the sentence state and updates it for one byte per enabled cycle.
// ----------------------------------------------------------------------------
module nsc_step import nsc_pkg::*; #(
    parameter int MAX_LEN = NSC_MAX_LEN
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic [7:0]   rx_byte,
    output logic         res_hit,
    output nsc_verdict_t verdict
);

    localparam int               CNT_W     = $clog2(MAX_LEN);
    localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_LEN - 2);
    localparam logic [CNT_W-1:0] ADDR_END  = CNT_W'(ADDR_LEN);

    logic             in_sentence_reg, in_sentence_next;
    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic [7:0]       running_xor_reg, running_xor_next;
    sum_phase_t       sum_phase_reg, sum_phase_next;
    logic [7:0]       received_sum_reg, received_sum_next;
    logic             hex_error_reg, hex_error_next;
    type_match_t      type_match_reg, type_match_next;
    logic [4:0]       field_index_reg, field_index_next;
    logic [7:0]       fix_store_reg, fix_store_next;
    logic [7:0]       status_store_reg, status_store_next;
    logic [1:0]       comma_run_reg, comma_run_next;
    logic             triple_reg, triple_next;
    logic             too_long_reg, too_long_next;

    logic [4:0]  hex_v;
    logic [2:0]  apos;
    logic        short_addr;
    type_match_t tm_final;
    logic [1:0]  stype;
    logic        sum_ok;
    logic        bad;
    logic [7:0]  fixc;
    logic [7:0]  statc;

    assign hex_v = hex_value(rx_byte);
    assign apos  = char_count_reg[2:0];
    assign short_addr = (field_index_reg == 5'd0) && (char_count_reg < ADDR_END);

    always_comb begin
        in_sentence_next  = in_sentence_reg;
        char_count_next   = char_count_reg;
        running_xor_next  = running_xor_reg;
        sum_phase_next    = sum_phase_reg;
        received_sum_next = received_sum_reg;
        hex_error_next    = hex_error_reg;
        type_match_next   = type_match_reg;
        field_index_next  = field_index_reg;
        fix_store_next    = fix_store_reg;
        status_store_next = status_store_reg;
        comma_run_next    = comma_run_reg;
        triple_next       = triple_reg;
        too_long_next     = too_long_reg;
        if (rx_byte == CH_DOLLAR) begin
            in_sentence_next  = 1'b1;
            char_count_next   = '0;
            running_xor_next  = 8'h00;
            sum_phase_next    = SP_BODY;
            received_sum_next = 8'h00;
            hex_error_next    = 1'b0;
            type_match_next   = TM_PREFIX;
            field_index_next  = 5'd0;
            fix_store_next    = 8'h00;
            status_store_next = 8'h00;
            comma_run_next    = 2'd0;
            triple_next       = 1'b0;
            too_long_next     = 1'b0;
        end else if (!in_sentence_reg) begin
            in_sentence_next = 1'b0;
        end else if (rx_byte == CH_CR) begin
            in_sentence_next = 1'b0;
        end else if (too_long_reg) begin
            too_long_next = 1'b1;
        end else if (char_count_reg >= LEN_LIMIT) begin
            too_long_next = 1'b1;
        end else begin
            char_count_next = char_count_reg + 1'b1;
            unique case (sum_phase_reg)
                SP_BODY: begin
                    if (rx_byte == CH_STAR) begin
                        if (short_addr) begin
                            type_match_next = TM_NONE;
                        end
                        sum_phase_next = SP_HI;
                    end else begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                        if (field_index_reg == 5'd0) begin
                            if (char_count_reg < ADDR_END) begin
                                unique case (type_match_reg)
                                    TM_PREFIX: begin
                                        if (apos < 3'd2) begin
                                            if (rx_byte != gga_char(apos)) begin
                                                type_match_next = TM_NONE;
                                            end
                                        end else if (rx_byte == CH_G) begin
                                            type_match_next = TM_GGA;
                                        end else if (rx_byte == CH_R) begin
                                            type_match_next = TM_RMC;
                                        end else begin
                                            type_match_next = TM_NONE;
                                        end
                                    end
                                    TM_GGA: begin
                                        if (rx_byte != gga_char(apos)) begin
                                            type_match_next = TM_NONE;
                                        end
                                    end
                                    TM_RMC: begin
                                        if (rx_byte != rmc_char(apos)) begin
                                            type_match_next = TM_NONE;
                                        end
                                    end
                                    default: begin
                                        type_match_next = TM_NONE;
                                    end
                                endcase
                            end else if (rx_byte != CH_COMMA) begin
                                type_match_next = TM_NONE;
                            end
                        end
                        if (rx_byte == CH_COMMA) begin
                            if (field_index_reg != FIELD_MAX) begin
                                field_index_next = field_index_reg + 5'd1;
                            end
                            if (comma_run_reg != COMMA_MAX) begin
                                comma_run_next = comma_run_reg + 2'd1;
                            end
                            if (comma_run_reg >= 2'd2) begin
                                triple_next = 1'b1;
                            end
                        end else begin
                            if (comma_run_reg != 2'd0) begin
                                if (field_index_reg == FIELD_FIX) begin
                                    fix_store_next = rx_byte;
                                end
                                if (field_index_reg == FIELD_STATUS) begin
                                    status_store_next = rx_byte;
                                end
                            end
                            comma_run_next = 2'd0;
                        end
                    end
                end
                SP_HI: begin
                    received_sum_next = {hex_v[3:0], 4'h0};
                    hex_error_next    = hex_error_reg | hex_v[4];
                    sum_phase_next    = SP_LO;
                end
                SP_LO: begin
                    received_sum_next = {received_sum_reg[7:4], hex_v[3:0]};
                    hex_error_next    = hex_error_reg | hex_v[4];
                    sum_phase_next    = SP_DONE;
                end
                default: begin
                    sum_phase_next = SP_DONE;
                end
            endcase
        end
    end

    always_comb begin
        res_hit  = in_sentence_reg && (rx_byte == CH_CR);
        tm_final = (sum_phase_reg == SP_BODY && short_addr) ? TM_NONE : type_match_reg;
        if (tm_final == TM_GGA) begin
            stype = TYPE_GGA;
        end else if (tm_final == TM_RMC) begin
            stype = TYPE_RMC;
        end else begin
            stype = TYPE_OTHER;
        end
        bad    = too_long_reg || hex_error_reg || (sum_phase_reg != SP_DONE);
        sum_ok = (sum_phase_reg == SP_DONE) && !hex_error_reg
                 && (received_sum_reg == running_xor_reg);
        fixc   = (stype == TYPE_GGA) ? fix_store_reg : 8'h00;
        statc  = (stype == TYPE_RMC) ? status_store_reg : 8'h00;
        verdict.sentence_type  = stype;
        verdict.checksum_ok    = sum_ok;
        verdict.checksum_value = running_xor_reg;
        verdict.fix_char       = fixc;
        verdict.status_char    = statc;
        verdict.malformed      = bad;
        verdict.accepted       = 1'b0;
        if (stype != TYPE_OTHER && sum_ok && !bad) begin
            if (stype == TYPE_GGA) begin
                verdict.accepted = (fixc != 8'h00) && (fixc != CH_ZERO) && !triple_reg;
            end else begin
                verdict.accepted = (statc != 8'h00) && (statc != CH_V);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg  <= 1'b0;
            char_count_reg   <= '0;
            running_xor_reg  <= 8'h00;
            sum_phase_reg    <= SP_BODY;
            received_sum_reg <= 8'h00;
            hex_error_reg    <= 1'b0;
            type_match_reg   <= TM_NONE;
            field_index_reg  <= 5'd0;
            fix_store_reg    <= 8'h00;
            status_store_reg <= 8'h00;
            comma_run_reg    <= 2'd0;
            triple_reg       <= 1'b0;
            too_long_reg     <= 1'b0;
        end else if (step_en) begin
            in_sentence_reg  <= in_sentence_next;
            char_count_reg   <= char_count_next;
            running_xor_reg  <= running_xor_next;
            sum_phase_reg    <= sum_phase_next;
            received_sum_reg <= received_sum_next;
            hex_error_reg    <= hex_error_next;
            type_match_reg   <= type_match_next;
            field_index_reg  <= field_index_next;
            fix_store_reg    <= fix_store_next;
            status_store_reg <= status_store_next;
            comma_run_reg    <= comma_run_next;
            triple_reg       <= triple_next;
            too_long_reg     <= too_long_next;
        end
    end

endmodule

>>> hw/rtl/nsc_out_reg.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker result register
// Holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module nsc_out_reg import nsc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  nsc_verdict_t verdict_in,
    input  logic         take,
    output logic         out_free,
    output logic         out_valid,
    output nsc_verdict_t verdict_out
);

    logic         valid_reg, valid_next;
    nsc_verdict_t data_reg;

    assign out_free    = !valid_reg || take;
    assign out_valid   = valid_reg;
    assign verdict_out = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= verdict_in;
        end
    end

endmodule

>>> hw/rtl/nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker
// A carriage return accepted into the input byte register is loaded into the result
// register once that register is free, and its verdict is then shown on m_*.
// Throughput: one byte per cycle; a byte that closes a sentence waits only while
// the result register still holds an earlier verdict that has not been taken.
// Reset: aresetn low clears the input valid flag, the sentence state and the result
// register's valid flag; the block is outside any sentence afterwards.
// ----------------------------------------------------------------------------
module nmea_sentence_checker import nsc_pkg::*; #(
    parameter int MAX_LEN = NSC_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits 7:0 rx_byte.
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bit 0 checksum_ok, bits 8:1 checksum_value, bit 9 accepted,
    // bits 17:10 fix_char, bits 25:18 status_char, bit 26 malformed, rest zero.
    output logic [31:0] m_tdata,
    // Bits 1:0 sentence_type.
    output logic [1:0]  m_tuser
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         res_hit;
    logic         out_free;
    logic         advance;
    nsc_verdict_t verdict;
    nsc_verdict_t verdict_q;

    assign advance  = in_valid_reg && (!res_hit || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    nsc_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .res_hit (res_hit),
        .verdict (verdict)
    );

    nsc_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance && res_hit),
        .verdict_in  (verdict),
        .take        (m_tready),
        .out_free    (out_free),
        .out_valid   (m_tvalid),
        .verdict_out (verdict_q)
    );

    assign m_tuser = verdict_q.sentence_type;
    assign m_tdata = {5'b00000, verdict_q.malformed, verdict_q.status_char,
                      verdict_q.fix_char, verdict_q.accepted,
                      verdict_q.checksum_value, verdict_q.checksum_ok};

    a_accept_needs_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && verdict_q.accepted |->
            verdict_q.checksum_ok && !verdict_q.malformed
            && verdict_q.sentence_type != TYPE_OTHER)
        else $error("accepted verdict without good checksum or known type");

    a_fix_only_gga: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && verdict_q.fix_char != 8'h00 |-> verdict_q.sentence_type == TYPE_GGA)
        else $error("fix character reported for a non-GGA sentence");

    a_status_only_rmc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && verdict_q.status_char != 8'h00 |-> verdict_q.sentence_type == TYPE_RMC)
        else $error("status character reported for a non-RMC sentence");

    a_held_byte_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input byte lost or changed");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_hit |-> !m_tvalid || m_tready)
        else $error("verdict loaded over one not yet taken");

endmodule

>>> bench/nsc_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker scoreboard
// Tracks each received byte, works out the verdict that a closing carriage
// return should produce, and compares the verdicts of the checker against it.
// ----------------------------------------------------------------------------
package nsc_scoreboard_pkg;

    import nsc_pkg::*;

    class nsc_scoreboard;

        localparam int REPORT_LIMIT = 10;

        int unsigned  max_len;
        string        gga_id = "GPGGA";
        string        rmc_id = "GPRMC";

        bit           open;
        int unsigned  n_chars;
        logic [7:0]   body_xor;
        sum_phase_t   phase;
        logic [7:0]   rx_sum;
        bit           bad_hex;
        type_match_t  tmatch;
        logic [4:0]   field_no;
        logic [7:0]   fix_seen;
        logic [7:0]   status_seen;
        logic [1:0]   commas;
        bit           triple;
        bit           overlong;

        nsc_verdict_t pending_verdicts[$];
        int           mismatches;
        int           verdict_no;

        function new(int unsigned max_len);
            this.max_len = max_len;
            start_sentence();
            open = 1'b0;
            tmatch = TM_NONE;
            mismatches = 0;
            verdict_no = 0;
        endfunction

        function void start_sentence();
            open = 1'b1;
            n_chars = 0;
            body_xor = '0;
            phase = SP_BODY;
            rx_sum = '0;
            bad_hex = 1'b0;
            tmatch = TM_PREFIX;
            field_no = '0;
            fix_seen = '0;
            status_seen = '0;
            commas = '0;
            triple = 1'b0;
            overlong = 1'b0;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function logic [3:0] hex_nibble(logic [7:0] b);
            if (b >= "0" && b <= "9") begin
                return 4'(b - 8'h30);
            end
            if (b >= "A" && b <= "F") begin
                return 4'(b - 8'h37);
            end
            if (b >= "a" && b <= "f") begin
                return 4'(b - 8'h57);
            end
            bad_hex = 1'b1;
            return 4'h0;
        endfunction

        function void body_char(logic [7:0] b, int unsigned pos);
            if (b == CH_STAR) begin
                if (field_no == 0 && pos < ADDR_LEN) begin
                    tmatch = TM_NONE;
                end
                phase = SP_HI;
                return;
            end
            body_xor ^= b;
            if (field_no == 0) begin
                if (pos < ADDR_LEN) begin
                    case (tmatch)
                        TM_PREFIX: begin
                            if (pos < 2) begin
                                if (b != gga_id[pos]) tmatch = TM_NONE;
                            end else if (b == CH_G) begin
                                tmatch = TM_GGA;
                            end else if (b == CH_R) begin
                                tmatch = TM_RMC;
                            end else begin
                                tmatch = TM_NONE;
                            end
                        end
                        TM_GGA: if (b != gga_id[pos]) tmatch = TM_NONE;
                        TM_RMC: if (b != rmc_id[pos]) tmatch = TM_NONE;
                        default: ;
                    endcase
                end else if (b != CH_COMMA) begin
                    tmatch = TM_NONE;
                end
            end
            if (b == CH_COMMA) begin
                if (field_no != FIELD_MAX) field_no++;
                if (commas != COMMA_MAX) commas++;
                if (commas == COMMA_MAX) triple = 1'b1;
            end else begin
                if (commas != 0) begin
                    if (field_no == FIELD_FIX) fix_seen = b;
                    if (field_no == FIELD_STATUS) status_seen = b;
                end
                commas = '0;
            end
        endfunction

        // Called for every request that the checker accepts.
        function void note_byte(logic [7:0] b);
            int unsigned  pos;
            nsc_verdict_t v;
            if (b == CH_DOLLAR) begin
                start_sentence();
                return;
            end
            if (!open) return;
            if (b == CH_CR) begin
                if (phase == SP_BODY && field_no == 0 && n_chars < ADDR_LEN) begin
                    tmatch = TM_NONE;
                end
                v = '0;
                v.sentence_type = (tmatch == TM_GGA) ? TYPE_GGA :
                                  (tmatch == TM_RMC) ? TYPE_RMC : TYPE_OTHER;
                v.malformed = overlong || bad_hex || phase != SP_DONE;
                v.checksum_ok = phase == SP_DONE && !bad_hex && rx_sum == body_xor;
                v.checksum_value = body_xor;
                v.fix_char = (v.sentence_type == TYPE_GGA) ? fix_seen : 8'h00;
                v.status_char = (v.sentence_type == TYPE_RMC) ? status_seen : 8'h00;
                if (v.checksum_ok && !v.malformed) begin
                    if (v.sentence_type == TYPE_GGA) begin
                        v.accepted = v.fix_char != 0 && v.fix_char != CH_ZERO && !triple;
                    end else if (v.sentence_type == TYPE_RMC) begin
                        v.accepted = v.status_char != 0 && v.status_char != CH_V;
                    end
                end
                pending_verdicts.push_back(v);
                open = 1'b0;
                return;
            end
            if (overlong) return;
            if (n_chars >= max_len - 2) begin
                overlong = 1'b1;
                return;
            end
            pos = n_chars;
            n_chars++;
            case (phase)
                SP_BODY: body_char(b, pos);
                SP_HI: begin
                    rx_sum = {hex_nibble(b), 4'h0};
                    phase = SP_LO;
                end
                SP_LO: begin
                    rx_sum[3:0] = hex_nibble(b);
                    phase = SP_DONE;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("verdict %0d: %s expected 0x%02h, got 0x%02h",
                             verdict_no, name, want, got);
                end
                mismatches++;
            end
        endfunction

        function void check_verdict(logic [31:0] data, logic [1:0] user);
            nsc_verdict_t want;
            verdict_no++;
            if (pending_verdicts.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("verdict %0d: unexpected, data 0x%08h type %0d",
                             verdict_no, data, user);
                end
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("sentence_type", 8'(want.sentence_type), 8'(user));
            compare_field("checksum_ok", 8'(want.checksum_ok), 8'(data[0]));
            compare_field("checksum_value", want.checksum_value, data[8:1]);
            compare_field("accepted", 8'(want.accepted), 8'(data[9]));
            compare_field("fix_char", want.fix_char, data[17:10]);
            compare_field("status_char", want.status_char, data[25:18]);
            compare_field("malformed", 8'(want.malformed), 8'(data[26]));
            compare_field("padding", 8'h00, 8'(data[31:27]));
        endfunction

    endclass

endpackage

>>> bench/tb_nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker testbench
// Sends directed and random byte streams (well-formed GGA and RMC sentences,
// checksum faults, short and overlong sentences, line noise) under varying
// source idling and sink back-pressure, and checks every verdict in order.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker;

    timeunit 1ns;
    timeprecision 1ps;

    import nsc_pkg::*;
    import nsc_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int BYTES_PER_PHASE = 185;

    typedef logic [7:0] byte_list_t[$];

    typedef enum int {
        TAIL_UPPER,
        TAIL_LOWER,
        TAIL_WRONG,
        TAIL_NO_STAR,
        TAIL_ONE_DIGIT,
        TAIL_BAD_HEX,
        TAIL_TRAILING
    } tail_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    nsc_scoreboard sb;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;

    nmea_sentence_checker #(
        .MAX_LEN(NSC_MAX_LEN)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_byte(s_tdata);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_verdict(m_tdata, m_tuser);
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
        end
    end

    function automatic byte_list_t text_bytes(string s);
        byte_list_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 4'd10) return 8'h30 + 8'(n);
        if (lower) return 8'h61 + 8'(n) - 8'd10;
        return 8'h41 + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] body_char();
        int unsigned r;
        logic [7:0]  c;
        r = $urandom_range(99, 0);
        if (r < 50) return 8'h30 + 8'($urandom_range(9, 0));
        if (r < 75) return 8'h41 + 8'($urandom_range(25, 0));
        if (r < 85) return 8'h61 + 8'($urandom_range(25, 0));
        if (r < 90) return 8'h2E;
        do begin
            c = 8'($urandom_range(255, 0));
        end while (c == CH_DOLLAR || c == CH_CR || c == CH_STAR);
        return c;
    endfunction

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_bytes(byte_list_t q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic send_frame(byte_list_t body, tail_t tail);
        logic [7:0] sum;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] junk;
        sum = '0;
        foreach (body[i]) sum ^= body[i];
        if (tail == TAIL_WRONG) sum ^= 8'($urandom_range(255, 1));
        hi = hex_char(sum[7:4], tail == TAIL_LOWER);
        lo = hex_char(sum[3:0], tail == TAIL_LOWER);
        if (tail == TAIL_BAD_HEX) begin
            do begin
                junk = 8'($urandom_range(255, 0));
            end while ((junk >= "0" && junk <= "9") || (junk >= "A" && junk <= "F") ||
                       (junk >= "a" && junk <= "f") || junk == CH_DOLLAR || junk == CH_CR);
            if ($urandom_range(1, 0) == 0) hi = junk;
            else lo = junk;
        end
        send_byte(CH_DOLLAR);
        send_bytes(body);
        if (tail != TAIL_NO_STAR) begin
            send_byte(CH_STAR);
            send_byte(hi);
            if (tail != TAIL_ONE_DIGIT) send_byte(lo);
        end
        if (tail == TAIL_TRAILING) send_bytes(text_bytes(",,,7*Z"));
        send_byte(CH_CR);
    endtask

    task automatic random_sentence();
        byte_list_t  body;
        int unsigned kind;
        int unsigned nfields;
        int unsigned flen;
        int unsigned r;
        tail_t       tail;
        kind = $urandom_range(9, 0);
        if (kind < 4) begin
            body = text_bytes("GPGGA");
            nfields = $urandom_range(8, 4);
        end else if (kind < 7) begin
            body = text_bytes("GPRMC");
            nfields = $urandom_range(5, 1);
        end else begin
            if (kind == 7) body = text_bytes("GP");
            for (int i = $urandom_range(6, 0); i > 0; i--) begin
                body.push_back(8'h41 + 8'($urandom_range(25, 0)));
            end
            nfields = $urandom_range(4, 0);
        end
        for (int f = 1; f <= nfields; f++) begin
            body.push_back(CH_COMMA);
            r = $urandom_range(5, 0);
            if (kind < 4 && f == FIELD_FIX) begin
                if (r == 1) body.push_back(CH_ZERO);
                else if (r > 1) body.push_back(8'h30 + 8'($urandom_range(8, 1)));
            end else if (kind >= 4 && kind < 7 && f == FIELD_STATUS) begin
                if (r == 1) body.push_back(CH_V);
                else if (r == 2) body.push_back(body_char());
                else if (r > 2) body.push_back("A");
            end else begin
                flen = (r == 0) ? 0 : $urandom_range(3, 1);
                for (int i = 0; i < flen; i++) body.push_back(body_char());
            end
        end
        r = $urandom_range(99, 0);
        if (r < 45) tail = TAIL_UPPER;
        else if (r < 85) tail = TAIL_LOWER;
        else tail = tail_t'($urandom_range(TAIL_TRAILING, TAIL_WRONG));
        send_frame(body, tail);
    endtask

    task automatic random_item();
        int unsigned r;
        byte_list_t  q;
        r = $urandom_range(99, 0);
        if (r < 6) begin
            for (int i = $urandom_range(8, 1); i > 0; i--) q.push_back(8'($urandom_range(255, 0)));
            send_bytes(q);
        end else if (r < 10) begin
            q.push_back(CH_DOLLAR);
            for (int i = $urandom_range(8, 0); i > 0; i--) q.push_back(body_char());
            send_bytes(q);
        end else if (r < 12) begin
            for (int i = $urandom_range(130, 120); i > 0; i--) q.push_back(body_char());
            send_frame(q, TAIL_UPPER);
        end else begin
            random_sentence();
        end
    endtask

    initial begin
        byte_list_t q;
        int         phase_end;
        int         idle_pct_of[4];
        int         stall_pct_of[4];
        idle_pct_of = '{0, 45, 0, 35};
        stall_pct_of = '{0, 0, 45, 35};
        sb = new(NSC_MAX_LEN);
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_bytes('{8'h00, 8'hFF, "x", CH_CR, CH_STAR});
        send_frame(text_bytes("GPGGA,1,2,3,4,5,1"), TAIL_UPPER);
        send_frame(text_bytes("GPGGA,1,2,3,4,5,0"), TAIL_LOWER);
        send_frame(text_bytes("GPGGA,,,,,,2"), TAIL_UPPER);
        send_frame(text_bytes("GPRMC,1,A"), TAIL_LOWER);
        send_frame(text_bytes("GPRMC,1,V"), TAIL_UPPER);
        send_frame(text_bytes("GPRMC,1,,A"), TAIL_UPPER);
        send_frame(text_bytes("GPRMC,1,A"), TAIL_WRONG);
        send_frame(text_bytes("GPGGA,1"), TAIL_NO_STAR);
        send_frame(text_bytes("GPRMC,1,A"), TAIL_ONE_DIGIT);
        send_frame(text_bytes("GPGGA,1,2,3,4,5,1"), TAIL_BAD_HEX);
        send_frame(text_bytes("GPRMC,1,A"), TAIL_TRAILING);
        send_frame(text_bytes("AA"), TAIL_UPPER);
        send_frame(text_bytes("GPGG"), TAIL_UPPER);
        send_frame(text_bytes("GPGGAX,1"), TAIL_UPPER);
        send_frame('{"G", "P", 8'hFF, 8'h80, 8'h00, 8'h7F, CH_COMMA, 8'h01}, TAIL_UPPER);
        send_bytes(text_bytes("$GPRMC,1"));
        send_frame(text_bytes("GPRMC,2,A"), TAIL_UPPER);
        send_bytes('{CH_DOLLAR, CH_CR});
        for (int i = 0; i < NSC_MAX_LEN - 5; i++) q.push_back("7");
        send_frame(q, TAIL_UPPER);
        q.push_back("7");
        send_frame(q, TAIL_UPPER);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = idle_pct_of[p];
            snk_stall_pct <= stall_pct_of[p];
            if (p == 0) hold_asked <= hold_asked + 1;
            phase_end = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < phase_end) random_item();
        end

        s_tvalid <= 1'b0;
        snk_stall_pct <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/nsc_pkg.sv
hw/rtl/nsc_step.sv
hw/rtl/nsc_out_reg.sv
hw/rtl/nmea_sentence_checker.sv
bench/nsc_scoreboard_pkg.sv
bench/tb_nmea_sentence_checker.sv
